FILE: hdl/multi_keyword_matcher_macros.svh
// Assertion macros for the multi-keyword matcher.
`ifndef MULTI_KEYWORD_MATCHER_MACROS_SVH
`define MULTI_KEYWORD_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define MKM_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("mkm check failed");
`define MKM_CHECK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mkm implication failed");
`define MKM_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mkm next-cycle check failed");
`else
`define MKM_CHECK(lbl, cond)
`define MKM_CHECK_IMP(lbl, ante, cons)
`define MKM_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/mkm_pkg.sv
// Shared types and request/status codes of the multi-keyword matcher.
package mkm_pkg;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;
  typedef logic [6:0] symbol_t;

  localparam kind_t KIND_KEY     = 2'd0;
  localparam kind_t KIND_COMPILE = 2'd1;
  localparam kind_t KIND_TEXT    = 2'd2;
  localparam kind_t KIND_CLEAR   = 2'd3;

  localparam status_t STAT_OK           = 2'd0;
  localparam status_t STAT_STATES_FULL  = 2'd1;
  localparam status_t STAT_KEYWORDS_FULL = 2'd2;
  localparam status_t STAT_NOT_COMPILED = 2'd3;
endpackage

FILE: hdl/multi_keyword_matcher.sv
// Multi-keyword matcher: trie build, breadth-first compile and text scan.
//
// Requests enter on start/in_kind/in_symbol/in_last and are taken when start
// is high and busy is low. Keyword symbols (in_last ends a keyword) grow a trie
// in the goto memory; a compile request walks the trie breadth-first through a
// state queue, writing fail links and merging output masks, then answers with
// out_from_compile set and the overflow status. Text symbols then run through
// the machine; the symbol carrying in_last yields one result saying whether
// any keyword occurred in that string. Results show for one cycle on
// out_strobe and cannot be held off; the next request may enter meanwhile.
// The goto and node memories have registered reads. The final keyword
// symbol passes through ST_KW_M for the mask update, and a text symbol
// passes through ST_TX_F and ST_TX_G again for each fail link followed; an
// ignored keyword symbol and any text symbol on an uncompiled machine are
// handled in ST_IDLE. Reset and a clear request start a clearing pass over
// all 2**(clog2(NODE_LIMIT)+clog2(ALPHABET)) goto entries (32768 by
// default) with busy high; output masks are cleared in the same pass.
`include "multi_keyword_matcher_macros.svh"
module multi_keyword_matcher #(
  parameter int NODE_LIMIT    = 256,
  parameter int ALPHABET      = 128,
  parameter int KEYWORD_LIMIT = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  mkm_pkg::kind_t   in_kind,
  input  mkm_pkg::symbol_t in_symbol,
  input  logic             in_last,
  output logic             out_strobe,
  output mkm_pkg::status_t out_status,
  output logic             out_matched,
  output logic             out_from_compile
);
  import mkm_pkg::*;

  localparam int SW    = $clog2(NODE_LIMIT);
  localparam int AW    = $clog2(ALPHABET);
  localparam int KW    = KEYWORD_LIMIT;
  localparam int GAW   = SW + AW;
  localparam int GW    = SW + 1;
  localparam int NW    = SW + KW;
  localparam int SUW   = SW + 1;
  localparam int KUW   = $clog2(KEYWORD_LIMIT + 1);
  localparam int GDEPTH = 1 << GAW;
  localparam logic [AW-1:0]  ALAST = AW'(ALPHABET - 1);
  localparam logic [GAW:0]   NCLR  = (GAW+1)'(NODE_LIMIT);

  localparam logic [4:0] ST_SWEEP = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_KW_G  = 5'd2;
  localparam logic [4:0] ST_KW_M  = 5'd3;
  localparam logic [4:0] ST_TX_G  = 5'd4;
  localparam logic [4:0] ST_TX_F  = 5'd5;
  localparam logic [4:0] ST_TX_M  = 5'd6;
  localparam logic [4:0] ST_RT_D  = 5'd7;
  localparam logic [4:0] ST_RT_W  = 5'd8;
  localparam logic [4:0] ST_BQ    = 5'd9;
  localparam logic [4:0] ST_BQ_D  = 5'd10;
  localparam logic [4:0] ST_BF    = 5'd11;
  localparam logic [4:0] ST_BG_D  = 5'd12;
  localparam logic [4:0] ST_AG_D  = 5'd13;
  localparam logic [4:0] ST_AF    = 5'd14;
  localparam logic [4:0] ST_MT    = 5'd15;
  localparam logic [4:0] ST_MC    = 5'd16;

  // Memories: goto entries {present, next}, nodes {fail, mask}, state queue
  logic [GW-1:0] gt_mem [GDEPTH];
  logic [NW-1:0] nd_mem [NODE_LIMIT];
  logic [SW-1:0] q_mem  [NODE_LIMIT];

  logic           gt_we;
  logic [GAW-1:0] gt_waddr, gt_raddr;
  logic [GW-1:0]  gt_wdata, gt_rdata_r;
  logic           nd_we;
  logic [SW-1:0]  nd_waddr, nd_raddr;
  logic [NW-1:0]  nd_wdata, nd_rdata_r;
  logic           q_we;
  logic [SW-1:0]  q_waddr, q_raddr;
  logic [SW-1:0]  q_wdata, q_rdata_r;

  logic [4:0]     state_r, state_nxt;
  logic [GAW-1:0] cnt_r, cnt_nxt;
  logic [SUW-1:0] st_used_r, st_used_nxt;
  logic [KUW-1:0] kw_used_r, kw_used_nxt;
  logic [SW-1:0]  build_r, build_nxt;
  logic [SW-1:0]  scan_r, scan_nxt;
  logic           hit_r, hit_nxt;
  logic           compiled_r, compiled_nxt;
  logic [1:0]     ovf_r, ovf_nxt;
  logic [AW-1:0]  sym_r, sym_nxt;
  logic           last_r, last_nxt;
  logic [AW-1:0]  ac_r, ac_nxt;
  logic [SW-1:0]  head_r, head_nxt;
  logic [SW-1:0]  tail_r, tail_nxt;
  logic [SW-1:0]  s_r, s_nxt;
  logic [SW-1:0]  fs_r, fs_nxt;
  logic [SW-1:0]  cur_r, cur_nxt;
  logic [SW-1:0]  c_r, c_nxt;
  logic [SW-1:0]  t_r, t_nxt;
  logic [KW-1:0]  mt_r, mt_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  status_t        out_status_r, out_status_nxt;
  logic           out_matched_r, out_matched_nxt;
  logic           out_from_compile_r, out_from_compile_nxt;

  logic [AW-1:0]  sym_mod [128];
  logic [AW-1:0]  sym_a;
  logic           accept;
  logic           gt_hit;
  logic [SW-1:0]  gt_id;
  logic [SW-1:0]  nd_fail;
  logic [KW-1:0]  nd_mask;
  logic           hit_new;

  // Reduce the symbol into the alphabet through a constant table
  for (genvar i = 0; i < 128; i++) begin : g_mod
    assign sym_mod[i] = AW'(i % ALPHABET);
  end
  assign sym_a = sym_mod[in_symbol];

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign gt_hit  = gt_rdata_r[SW];
  assign gt_id   = gt_rdata_r[SW-1:0];
  assign nd_fail = nd_rdata_r[NW-1:KW];
  assign nd_mask = nd_rdata_r[KW-1:0];
  assign hit_new = hit_r | (nd_mask != '0);

  // Goto memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (gt_we) begin
      gt_mem[gt_waddr] <= gt_wdata;
    end
    gt_rdata_r <= gt_mem[gt_raddr];
  end

  // Node memory
  always_ff @(posedge clk) begin
    if (nd_we) begin
      nd_mem[nd_waddr] <= nd_wdata;
    end
    nd_rdata_r <= nd_mem[nd_raddr];
  end

  // State queue
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata_r <= q_mem[q_raddr];
  end

  // Sequencer: decide next state, memory accesses and result
  always_comb begin
    state_nxt            = state_r;
    cnt_nxt              = cnt_r;
    st_used_nxt          = st_used_r;
    kw_used_nxt          = kw_used_r;
    build_nxt            = build_r;
    scan_nxt             = scan_r;
    hit_nxt              = hit_r;
    compiled_nxt         = compiled_r;
    ovf_nxt              = ovf_r;
    sym_nxt              = sym_r;
    last_nxt             = last_r;
    ac_nxt               = ac_r;
    head_nxt             = head_r;
    tail_nxt             = tail_r;
    s_nxt                = s_r;
    fs_nxt               = fs_r;
    cur_nxt              = cur_r;
    c_nxt                = c_r;
    t_nxt                = t_r;
    mt_nxt               = mt_r;
    out_strobe_nxt       = 1'b0;
    out_status_nxt       = out_status_r;
    out_matched_nxt      = out_matched_r;
    out_from_compile_nxt = out_from_compile_r;
    gt_we    = 1'b0;
    gt_waddr = {build_r, sym_r};
    gt_wdata = {1'b1, st_used_r[SW-1:0]};
    gt_raddr = {build_r, sym_a};
    nd_we    = 1'b0;
    nd_waddr = c_r;
    nd_wdata = '0;
    nd_raddr = t_r;
    q_we     = 1'b0;
    q_waddr  = tail_r;
    q_wdata  = gt_id;
    q_raddr  = head_r;

    unique case (state_r)
      ST_SWEEP: begin
        // Mark every goto entry absent, clear the output masks
        gt_we    = 1'b1;
        gt_waddr = cnt_r;
        gt_wdata = '0;
        if ({1'b0, cnt_r} < NCLR) begin
          nd_we    = 1'b1;
          nd_waddr = cnt_r[SW-1:0];
          nd_wdata = '0;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          sym_nxt  = sym_a;
          last_nxt = in_last;
          unique case (in_kind)
            KIND_KEY: begin
              compiled_nxt = 1'b0;
              if (ovf_r != STAT_OK) begin
                if (in_last) begin
                  build_nxt = '0;
                end
              end else if (build_r == '0 && kw_used_r >= KUW'(KEYWORD_LIMIT)) begin
                ovf_nxt = STAT_KEYWORDS_FULL;
              end else begin
                gt_raddr  = {build_r, sym_a};
                state_nxt = ST_KW_G;
              end
            end
            KIND_COMPILE: begin
              scan_nxt  = '0;
              hit_nxt   = 1'b0;
              ac_nxt    = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              gt_raddr  = '0;
              state_nxt = ST_RT_D;
            end
            KIND_TEXT: begin
              if (!compiled_r) begin
                if (in_last) begin
                  out_strobe_nxt       = 1'b1;
                  out_status_nxt       = STAT_NOT_COMPILED;
                  out_matched_nxt      = 1'b0;
                  out_from_compile_nxt = 1'b0;
                  scan_nxt             = '0;
                  hit_nxt              = 1'b0;
                end
              end else begin
                gt_raddr  = {scan_r, sym_a};
                cur_nxt   = scan_r;
                state_nxt = ST_TX_G;
              end
            end
            KIND_CLEAR: begin
              st_used_nxt  = SUW'(1);
              kw_used_nxt  = '0;
              build_nxt    = '0;
              scan_nxt     = '0;
              hit_nxt      = 1'b0;
              compiled_nxt = 1'b0;
              ovf_nxt      = STAT_OK;
              cnt_nxt      = '0;
              state_nxt    = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_KW_G: begin
        // Follow or create the trie edge for this keyword symbol
        state_nxt = ST_IDLE;
        if (!gt_hit && st_used_r >= SUW'(NODE_LIMIT)) begin
          ovf_nxt   = STAT_STATES_FULL;
          build_nxt = '0;
        end else begin
          if (!gt_hit) begin
            gt_we       = 1'b1;
            t_nxt       = st_used_r[SW-1:0];
            st_used_nxt = st_used_r + 1'b1;
          end else begin
            t_nxt = gt_id;
          end
          if (last_r) begin
            nd_raddr  = t_nxt;
            state_nxt = ST_KW_M;
          end else begin
            build_nxt = t_nxt;
          end
        end
      end
      ST_KW_M: begin
        // Set this keyword's bit in the final node's mask
        nd_we       = 1'b1;
        nd_waddr    = t_r;
        nd_wdata    = {nd_fail, nd_mask | (KW'(1) << kw_used_r)};
        kw_used_nxt = kw_used_r + 1'b1;
        build_nxt   = '0;
        state_nxt   = ST_IDLE;
      end
      ST_TX_G: begin
        // Take the edge, drop to the root, or fetch the fail link
        if (gt_hit) begin
          t_nxt     = gt_id;
          nd_raddr  = gt_id;
          state_nxt = ST_TX_M;
        end else if (cur_r == '0) begin
          t_nxt     = '0;
          nd_raddr  = '0;
          state_nxt = ST_TX_M;
        end else begin
          nd_raddr  = cur_r;
          state_nxt = ST_TX_F;
        end
      end
      ST_TX_F: begin
        cur_nxt   = nd_fail;
        gt_raddr  = {nd_fail, sym_r};
        state_nxt = ST_TX_G;
      end
      ST_TX_M: begin
        // Record a hit and close the string on its final symbol
        scan_nxt  = t_r;
        hit_nxt   = hit_new;
        state_nxt = ST_IDLE;
        if (last_r) begin
          out_strobe_nxt       = 1'b1;
          out_status_nxt       = STAT_OK;
          out_matched_nxt      = hit_new;
          out_from_compile_nxt = 1'b0;
          scan_nxt             = '0;
          hit_nxt              = 1'b0;
        end
      end
      ST_RT_D: begin
        // Root children: fail to the root and join the queue
        if (gt_hit) begin
          c_nxt     = gt_id;
          nd_raddr  = gt_id;
          q_we      = 1'b1;
          tail_nxt  = tail_r + 1'b1;
          state_nxt = ST_RT_W;
        end else if (ac_r == ALAST) begin
          state_nxt = ST_BQ;
        end else begin
          ac_nxt    = ac_r + 1'b1;
          gt_raddr  = {{SW{1'b0}}, ac_r + 1'b1};
          state_nxt = ST_RT_D;
        end
      end
      ST_RT_W: begin
        nd_we    = 1'b1;
        nd_waddr = c_r;
        nd_wdata = {{SW{1'b0}}, nd_mask};
        if (ac_r == ALAST) begin
          state_nxt = ST_BQ;
        end else begin
          ac_nxt    = ac_r + 1'b1;
          gt_raddr  = {{SW{1'b0}}, ac_r + 1'b1};
          state_nxt = ST_RT_D;
        end
      end
      ST_BQ: begin
        // Pop the next state, or finish the compile
        if (head_r < tail_r) begin
          q_raddr   = head_r;
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_BQ_D;
        end else begin
          out_strobe_nxt       = 1'b1;
          out_status_nxt       = ovf_r;
          out_matched_nxt      = 1'b0;
          out_from_compile_nxt = 1'b1;
          compiled_nxt         = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      ST_BQ_D: begin
        s_nxt     = q_rdata_r;
        nd_raddr  = q_rdata_r;
        state_nxt = ST_BF;
      end
      ST_BF: begin
        fs_nxt    = nd_fail;
        ac_nxt    = '0;
        gt_raddr  = {s_r, {AW{1'b0}}};
        state_nxt = ST_BG_D;
      end
      ST_BG_D: begin
        // Child found: queue it and search its fail target
        if (gt_hit) begin
          c_nxt     = gt_id;
          q_we      = 1'b1;
          tail_nxt  = tail_r + 1'b1;
          cur_nxt   = fs_r;
          gt_raddr  = {fs_r, ac_r};
          state_nxt = ST_AG_D;
        end else if (ac_r == ALAST) begin
          state_nxt = ST_BQ;
        end else begin
          ac_nxt    = ac_r + 1'b1;
          gt_raddr  = {s_r, ac_r + 1'b1};
          state_nxt = ST_BG_D;
        end
      end
      ST_AG_D: begin
        if (gt_hit) begin
          t_nxt     = gt_id;
          nd_raddr  = gt_id;
          state_nxt = ST_MT;
        end else if (cur_r == '0) begin
          t_nxt     = '0;
          nd_raddr  = '0;
          state_nxt = ST_MT;
        end else begin
          nd_raddr  = cur_r;
          state_nxt = ST_AF;
        end
      end
      ST_AF: begin
        cur_nxt   = nd_fail;
        gt_raddr  = {nd_fail, ac_r};
        state_nxt = ST_AG_D;
      end
      ST_MT: begin
        mt_nxt    = nd_mask;
        nd_raddr  = c_r;
        state_nxt = ST_MC;
      end
      ST_MC: begin
        // Write the fail link and merge the target's mask
        nd_we    = 1'b1;
        nd_waddr = c_r;
        nd_wdata = {t_r, nd_mask | mt_r};
        if (ac_r == ALAST) begin
          state_nxt = ST_BQ;
        end else begin
          ac_nxt    = ac_r + 1'b1;
          gt_raddr  = {s_r, ac_r + 1'b1};
          state_nxt = ST_BG_D;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      cnt_r        <= '0;
      st_used_r    <= SUW'(1);
      kw_used_r    <= '0;
      build_r      <= '0;
      scan_r       <= '0;
      hit_r        <= 1'b0;
      compiled_r   <= 1'b0;
      ovf_r        <= STAT_OK;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      st_used_r    <= st_used_nxt;
      kw_used_r    <= kw_used_nxt;
      build_r      <= build_nxt;
      scan_r       <= scan_nxt;
      hit_r        <= hit_nxt;
      compiled_r   <= compiled_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    sym_r              <= sym_nxt;
    last_r             <= last_nxt;
    ac_r               <= ac_nxt;
    head_r             <= head_nxt;
    tail_r             <= tail_nxt;
    s_r                <= s_nxt;
    fs_r               <= fs_nxt;
    cur_r              <= cur_nxt;
    c_r                <= c_nxt;
    t_r                <= t_nxt;
    mt_r               <= mt_nxt;
    out_status_r       <= out_status_nxt;
    out_matched_r      <= out_matched_nxt;
    out_from_compile_r <= out_from_compile_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_matched      = out_matched_r;
  assign out_from_compile = out_from_compile_r;

  // Checks
  `MKM_CHECK(a_states_range, st_used_r != '0 && st_used_r <= SUW'(NODE_LIMIT))
  `MKM_CHECK(a_keywords_range, kw_used_r <= KUW'(KEYWORD_LIMIT))
  `MKM_CHECK_IMP(a_compile_no_match, out_strobe && out_from_compile, !out_matched)
  `MKM_CHECK_NEXT(a_clear_busy, accept && in_kind == KIND_CLEAR, busy && !out_strobe)
endmodule
